// ===== rtl/core/led_dimming_pattern_mapper_unit_macros.svh =====
// assertion macros for the led dimming pattern mapper
// expects clk and arst_n in the scope of each use
`ifndef LED_DIMMING_PATTERN_MAPPER_UNIT_MACROS_SVH
`define LED_DIMMING_PATTERN_MAPPER_UNIT_MACROS_SVH

// same-cycle implication
`define LDPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LDPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ldpm_pkg.sv =====
// types and constants shared by the led dimming pattern mapper
// no dependencies
package ldpm_pkg;

	localparam int WORD_W       = 32;
	localparam int LED_IDX_W    = 3;
	localparam int PHASE_W      = 2;
	localparam int MAX_ASSIGN   = 8;
	localparam int CNT_W        = 6;
	localparam int DEF_NUM_LEDS  = 8;
	localparam int DEF_PIN_COUNT = 32;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic CFG_PIN_MASK = 1'b0;
	localparam logic CFG_ORDER    = 1'b1;

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] pattern;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  load_mask;
		logic [WORD_W-1:0]  load_value;
		logic [PHASE_W-1:0] phase_used;
	} result_t;

	// per-pin selection: pin drives an led, and which one
	typedef struct packed {
		logic                 en;
		logic [LED_IDX_W-1:0] led;
	} pin_sel_t;

endpackage

// ===== rtl/core/ldpm_pin_map.sv =====
// pin to led assignment table, rebuilt from the mask and order registers
// depends on ldpm_pkg
module ldpm_pin_map
	import ldpm_pkg::*;
#(
	parameter int NUM_LEDS  = DEF_NUM_LEDS,
	parameter int PIN_COUNT = DEF_PIN_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] pin_mask,
	input  logic [WORD_W-1:0] order,
	output pin_sel_t          pin_sel [PIN_COUNT]
);

	localparam logic [WORD_W:0] LIM_WIDE = (33'h1 << PIN_COUNT) - 33'h1;
	localparam logic [WORD_W-1:0] PIN_LIMIT = LIM_WIDE[WORD_W-1:0];

	logic [LED_IDX_W-1:0] nib [MAX_ASSIGN];
	logic [MAX_ASSIGN-1:0] eff;
	logic [CNT_W-1:0] total;
	pin_sel_t sel_d [PIN_COUNT];
	pin_sel_t sel_q [PIN_COUNT];

	assign total = CNT_W'($countones(pin_mask & PIN_LIMIT));

	// an assignment counts only if its led is below NUM_LEDS and no later used assignment names the same led
	always_comb begin
		for (int r = 0; r < MAX_ASSIGN; r++) begin
			nib[r] = order[4*r +: LED_IDX_W];
		end
		for (int r = 0; r < MAX_ASSIGN; r++) begin
			eff[r] = ({1'b0, nib[r]} < 4'(NUM_LEDS));
			for (int r2 = r + 1; r2 < MAX_ASSIGN; r2++) begin
				if ((CNT_W'(r2) < total) && (nib[r2] == nib[r])) begin
					eff[r] = 1'b0;
				end
			end
		end
	end

	for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
		localparam logic [WORD_W-1:0] BELOW = (32'h1 << p) - 32'h1;
		logic [CNT_W-1:0] rank;

		// rank of this pin among the set mask bits below it
		assign rank = CNT_W'($countones(pin_mask & BELOW));

		always_comb begin
			sel_d[p].led = nib[rank[LED_IDX_W-1:0]];
			sel_d[p].en  = pin_mask[p] && (rank < CNT_W'(MAX_ASSIGN))
				&& eff[rank[LED_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PIN_COUNT; p++) begin
				sel_q[p] <= '0;
			end
		end else begin
			for (int p = 0; p < PIN_COUNT; p++) begin
				sel_q[p] <= sel_d[p];
			end
		end
	end

	assign pin_sel = sel_q;

endmodule

// ===== rtl/core/led_dimming_pattern_mapper_unit.sv =====
// led dimming pattern mapper, top level
// depends on ldpm_pkg, ldpm_pin_map and the assertion macro header
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------
//  item     | item_valid/item_stall  | item_t: command, pattern
//  result   | result_valid/result_stall | result_t: mask, value, phase
//  config   | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// one word per cycle unless a tick waits on a stalled result: input
// register, then one level of bit-select logic into the result register
// the pin table is registered from the config registers in the next cycle
// a pattern load gives no result and never waits on the result side
// reset clears the phase, the pattern word, the config registers and the table
`include "led_dimming_pattern_mapper_unit_macros.svh"

module led_dimming_pattern_mapper_unit
	import ldpm_pkg::*;
#(
	parameter int NUM_LEDS  = DEF_NUM_LEDS,
	parameter int PIN_COUNT = DEF_PIN_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [WORD_W-1:0] cfg_data
);

	logic [WORD_W-1:0] pin_mask_q;
	logic [WORD_W-1:0] order_q;
	logic [WORD_W-1:0] bright_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_next;
	logic valid_s1;
	item_t item_s1;
	logic adv_s1;
	logic tick;
	logic out_free;
	logic result_valid_q;
	result_t result_q;
	logic [WORD_W-1:0] on_bits;
	pin_sel_t pin_sel [PIN_COUNT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_mask_q <= '0;
			order_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIN_MASK: pin_mask_q <= cfg_data;
				CFG_ORDER:    order_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	ldpm_pin_map #(
		.NUM_LEDS  (NUM_LEDS),
		.PIN_COUNT (PIN_COUNT)
	) u_pin_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.pin_mask (pin_mask_q),
		.order    (order_q),
		.pin_sel  (pin_sel)
	);

	assign out_free   = !result_valid_q || !result_stall;
	assign adv_s1     = valid_s1 && ((item_s1.command == CMD_LOAD) || out_free);
	assign tick       = adv_s1 && (item_s1.command == CMD_TICK);
	assign item_stall = valid_s1 && !adv_s1;
	assign phase_next = phase_q + PHASE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= '0;
			phase_q  <= '0;
		end else begin
			if (adv_s1 && (item_s1.command == CMD_LOAD)) begin
				bright_q <= item_s1.pattern;
			end
			if (tick) begin
				phase_q <= phase_next;
			end
		end
	end

	// pattern bit of the pin's led at the new phase: index led*4 + phase
	always_comb begin
		on_bits = '0;
		for (int p = 0; p < PIN_COUNT; p++) begin
			on_bits[p] = pin_sel[p].en && bright_q[{pin_sel[p].led, phase_next}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (tick) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			result_q.load_mask  <= pin_mask_q;
			result_q.load_value <= on_bits ^ pin_mask_q;
			result_q.phase_used <= phase_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`LDPM_ASSERT_NOW(a_stall_needs_word, item_stall, valid_s1, "stall without a held word")
	`LDPM_ASSERT_NEXT(a_phase_step, tick, phase_q == $past(phase_q) + PHASE_W'(1), "phase did not step")
	`LDPM_ASSERT_NEXT(a_load_keeps_phase, adv_s1 && (item_s1.command == CMD_LOAD), $stable(phase_q), "load moved phase")
	`LDPM_ASSERT_NOW(a_result_phase, result_valid_q, result_q.phase_used == phase_q, "result phase mismatch")

endmodule

// ===== tb/sv/tb_led_dimming_pattern_mapper_unit.sv =====
// self-checking testbench for led_dimming_pattern_mapper_unit
// predicts each tick's pin frame from a copy of the phase, pattern and config
// depends on ldpm_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_led_dimming_pattern_mapper_unit;
	import ldpm_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int END_LIMIT     = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	item_t             item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_PIN_MASK;
	logic [WORD_W-1:0] cfg_data = '0;

	// predictor state
	logic [WORD_W-1:0]  mask_now = '0;
	logic [WORD_W-1:0]  order_now = '0;
	logic [WORD_W-1:0]  pattern_now = '0;
	logic [PHASE_W-1:0] phase_now = '0;

	result_t frames_due[$];
	int      mismatch_count = 0;
	bit      sender_steady = 1'b0;
	bit      receiver_steady = 1'b0;
	int      hold_request = 0;
	int      hold_left = 0;

	led_dimming_pattern_mapper_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// advance the phase and build the active-low pin frame for one tick
	function automatic result_t predict_pin_frame();
		logic [4:0]              led_pin [DEF_NUM_LEDS];
		logic [DEF_NUM_LEDS-1:0] led_live;
		logic [WORD_W-1:0]       ord;
		logic [WORD_W-1:0]       lit;
		logic [LED_IDX_W-1:0]    led;
		int                      taken;
		result_t                 r;
		led_live = '0;
		ord = order_now;
		lit = '0;
		taken = 0;
		for (int k = 0; k < DEF_NUM_LEDS; k++)
			led_pin[k] = '0;
		for (int p = 0; p < DEF_PIN_COUNT; p++) begin
			if (mask_now[p] && taken < MAX_ASSIGN) begin
				led = ord[LED_IDX_W-1:0];
				led_pin[led] = p[4:0];
				led_live[led] = 1'b1;
				taken++;
				ord = ord >> 4;
			end
		end
		phase_now = phase_now + 1'b1;
		for (int k = 0; k < DEF_NUM_LEDS; k++)
			if (led_live[k] && pattern_now[4 * k + phase_now])
				lit = lit | (32'b1 << led_pin[k]);
		r.load_mask = mask_now;
		r.load_value = lit ^ mask_now;
		r.phase_used = phase_now;
		return r;
	endfunction

	function automatic int sender_gap();
		int n;
		n = 0;
		if (!sender_steady)
			while ($urandom_range(99) < 35)
				n++;
		return n;
	endfunction

	// offer one word, wait for it to be taken, record what it should produce
	task automatic send_word(input logic cmd, input logic [WORD_W-1:0] pat);
		item_t w;
		int    gap;
		w.command = cmd;
		w.pattern = pat;
		gap = sender_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (cmd == CMD_LOAD)
			pattern_now = pat;
		else
			frames_due.push_back(predict_pin_frame());
	endtask

	task automatic send_random_word();
		send_word(($urandom_range(99) < 30) ? CMD_LOAD : CMD_TICK, $urandom);
	endtask

	// stop offering and let every outstanding frame come out
	task automatic settle();
		item_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_PIN_MASK)
			mask_now = data;
		else
			order_now = data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [WORD_W-1:0] pins, input logic [WORD_W-1:0] ord);
		settle();
		write_reg(CFG_PIN_MASK, pins);
		write_reg(CFG_ORDER, ord);
		settle();
	endtask

	function automatic logic [WORD_W-1:0] random_mask();
		logic [WORD_W-1:0] m;
		m = '0;
		case ($urandom_range(4))
			0: m = '0;
			1: m = '1;
			2: m = $urandom;
			3: begin
				repeat ($urandom_range(1, 10))
					m = m | (32'b1 << $urandom_range(31));
			end
			default: m = 32'hff << $urandom_range(24);
		endcase
		return m;
	endfunction

	// ticks at reset config, then ticks at a new config before any pattern is loaded
	task automatic test_reset_defaults();
		repeat (2) send_word(CMD_TICK, $urandom);
		apply_setting(32'h0000_00ff, 32'h7654_3210);
		repeat (2) send_word(CMD_TICK, $urandom);
	endtask

	task automatic test_directed_patterns();
		send_word(CMD_LOAD, 32'hffff_ffff);
		repeat (4) send_word(CMD_TICK, 32'h0);
		send_word(CMD_LOAD, 32'h8421_8421);
		repeat (4) send_word(CMD_TICK, 32'hffff_ffff);
		// more than eight mask bits, reversed order
		apply_setting(32'hffff_ffff, 32'h0123_4567);
		send_word(CMD_LOAD, 32'ha5c3_f00f);
		repeat (4) send_word(CMD_TICK, 32'h0);
		// top pin, nibbles with the high bit set
		apply_setting(32'h8000_0001, 32'hffff_fff8);
		send_word(CMD_LOAD, 32'hf000_000f);
		repeat (2) send_word(CMD_TICK, 32'h0);
		// every pin names led 0, the last one wins
		apply_setting(32'h00f0_000f, 32'h0000_0000);
		send_word(CMD_LOAD, 32'h0000_0005);
		repeat (2) send_word(CMD_TICK, 32'h0);
	endtask

	task automatic test_random_traffic();
		for (int s = 0; s < 10; s++) begin
			case (s)
				0: apply_setting('1, '1);
				1: apply_setting('0, '0);
				2: apply_setting(32'h0000_00ff, $urandom);
				default: apply_setting(random_mask(), $urandom);
			endcase
			repeat (110) send_random_word();
		end
	endtask

	// long result hold-off while words keep coming, then a full drain and more random words
	task automatic test_backpressure();
		apply_setting($urandom, $urandom);
		sender_steady = 1'b1;
		hold_request = 80;
		repeat (40) send_random_word();
		sender_steady = 1'b0;
		settle();
		repeat (20) send_random_word();
	endtask

	task automatic test_steady_stream();
		apply_setting(random_mask(), $urandom);
		sender_steady = 1'b1;
		receiver_steady = 1'b1;
		repeat (200) send_random_word();
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (receiver_steady) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 35);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (frames_due.size() == 0) begin
				$error("unexpected result word: mask %h value %h phase %0d",
					result.load_mask, result.load_value, result.phase_used);
				mismatch_count++;
			end else begin
				result_t want;
				want = frames_due.pop_front();
				if (result.load_mask !== want.load_mask) begin
					$error("load_mask: expected %h, got %h", want.load_mask, result.load_mask);
					mismatch_count++;
				end
				if (result.load_value !== want.load_value) begin
					$error("load_value: expected %h, got %h", want.load_value,
						result.load_value);
					mismatch_count++;
				end
				if (result.phase_used !== want.phase_used) begin
					$error("phase_used: expected %0d, got %0d", want.phase_used,
						result.phase_used);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_patterns();
		test_random_traffic();
		test_backpressure();
		test_steady_stream();
		item_valid <= 1'b0;
		for (n = 0; n < END_LIMIT && frames_due.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (frames_due.size() != 0) begin
			$error("%0d result words never arrived", frames_due.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("led_dimming_pattern_mapper_unit verification clean");
		end else begin
			$display("led_dimming_pattern_mapper_unit verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("led_dimming_pattern_mapper_unit verification failed");
		$finish;
	end

endmodule
